[hdl/atsu_pkg.sv]
package atsu_pkg;

    localparam int WORD_W    = 16;
    localparam int RAW_W     = 12;
    localparam int VALUE_W   = 13;
    localparam int CHAN_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SEL_W     = 3;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_ADC_HDR      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TDC_LOW_HDR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TDC_HIGH_HDR = 2'd2;

    // header codes after reset
    localparam logic [WORD_W-1:0] ADC_HDR_RESET      = 16'h1007;
    localparam logic [WORD_W-1:0] TDC_LOW_HDR_RESET  = 16'h2005;
    localparam logic [WORD_W-1:0] TDC_HIGH_HDR_RESET = 16'h2006;

    // raw value that stands for zero
    localparam logic [RAW_W-1:0] RAW_OVERFLOW = 12'hfff;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_DATA  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        KIND_ADC      = 2'd0,
        KIND_TDC_LOW  = 2'd1,
        KIND_TDC_HIGH = 2'd2
    } kind_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take_word;
        logic load_item;
        logic preset;
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_valid;
        logic dump_last;
    } status_t;

    // preset of adc channel idx: -(idx+1)
    function automatic logic signed [VALUE_W-1:0] adc_preset(input int idx);
        int v;
        v = -(idx + 1);
        return VALUE_W'(v);
    endfunction

    // preset of tdc channel idx: -10*(idx+1)
    function automatic logic signed [VALUE_W-1:0] tdc_preset(input int idx);
        int v;
        v = -10 * (idx + 1);
        return VALUE_W'(v);
    endfunction

endpackage

[hdl/detector_adc_tdc_subevent_unpacker_top.sv]
// Subevent unpacker for one ADC bank and two TDC banks.
// Input stream: s_tdata carries one 16-bit readout word, s_tlast marks the
// last word of the subevent. Words are parsed for block headers, a count word
// and data words, and data values land in a channel store.
// Output stream: at each event end the block sends every channel, ADC first
// and then TDC, in rising channel order; m_tuser is 1 for TDC channels and
// m_tlast marks the final channel of the dump.
// Configuration: cfg_valid/cfg_index/cfg_data write the three header codes
// (0 = ADC, 1 = TDC low bank, 2 = TDC high bank); cfg_ready is always high,
// write only while no event dump is in progress.
// Throughput: one word per cycle while parsing. After the last word the block
// dumps the store, ADC_CHANNELS + TDC_CHANNELS results (24 by default), one
// result per cycle through the single output register; s_tready is low during
// the dump, whose first result is loaded once the controller is in ST_DUMP.
// A stalled receiver holds the output register and stretches the dump.
// Reset restores the header codes, clears the parser and loads the store with
// its preset pattern (ADC i = -(i+1), TDC i = -10(i+1)); the same preset is
// loaded when the last result of a dump is taken into the output register.
module detector_adc_tdc_subevent_unpacker_top #(
    parameter int ADC_CHANNELS = 8,
    parameter int TDC_CHANNELS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // word [15:0]
    input  logic [atsu_pkg::WORD_W-1:0]         s_tdata,
    input  logic                                s_tlast,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // channel [3:0], value [16:4], zero [23:17]
    output logic [23:0]                         m_tdata,
    // is_tdc [0]
    output logic                                m_tuser,
    output logic                                m_tlast,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [atsu_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [atsu_pkg::WORD_W-1:0]         cfg_data
);
    import atsu_pkg::*;

    cmd_t                      cmd;
    status_t                   status;
    logic [CHAN_W-1:0]         out_channel;
    logic signed [VALUE_W-1:0] out_value;

    // controller
    atsu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // parser, store and output register
    atsu_datapath #(
        .ADC_CHANNELS (ADC_CHANNELS),
        .TDC_CHANNELS (TDC_CHANNELS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .word        (s_tdata),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .out_is_tdc  (m_tuser),
        .out_channel (out_channel),
        .out_value   (out_value),
        .out_last    (m_tlast)
    );

    // configuration requests are always taken
    assign cfg_ready = 1'b1;

    // result packing
    assign m_tdata = {7'd0, out_value, out_channel};

endmodule

[hdl/atsu_ctrl.sv]
module atsu_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tlast,
    output logic              s_tready,
    input  logic              m_tready,
    input  atsu_pkg::status_t status,
    output atsu_pkg::cmd_t    cmd
);
    import atsu_pkg::*;

    typedef enum logic [1:0] {
        ST_PARSE = 2'b01,
        ST_DUMP  = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // handshake and commands
    always_comb
    begin
        s_tready      = (state_reg == ST_PARSE);
        cmd.take_word = s_tvalid && (state_reg == ST_PARSE);
        cmd.load_item = (state_reg == ST_DUMP) && (!status.out_valid || m_tready);
        cmd.preset    = cmd.load_item && status.dump_last;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PARSE:
            begin
                if (cmd.take_word && s_tlast)
                begin
                    state_next = ST_DUMP;
                end
            end
            ST_DUMP:
            begin
                if (cmd.preset)
                begin
                    state_next = ST_PARSE;
                end
            end
            default:
            begin
                state_next = ST_PARSE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_PARSE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/atsu_datapath.sv]
module atsu_datapath #(
    parameter int ADC_CHANNELS = 8,
    parameter int TDC_CHANNELS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  atsu_pkg::cmd_t                         cmd,
    output atsu_pkg::status_t                      status,
    input  logic [atsu_pkg::WORD_W-1:0]            word,
    input  logic                                   cfg_we,
    input  logic [atsu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [atsu_pkg::WORD_W-1:0]            cfg_data,
    input  logic                                   m_tready,
    output logic                                   out_valid,
    output logic                                   out_is_tdc,
    output logic [atsu_pkg::CHAN_W-1:0]            out_channel,
    output logic signed [atsu_pkg::VALUE_W-1:0]    out_value,
    output logic                                   out_last
);
    import atsu_pkg::*;

    localparam int TOTAL  = ADC_CHANNELS + TDC_CHANNELS;
    localparam int CNT_W  = $clog2(TOTAL);
    localparam int ADC_IW = (ADC_CHANNELS > 1) ? $clog2(ADC_CHANNELS) : 1;
    localparam int TDC_IW = $clog2(TDC_CHANNELS);

    // header code registers
    logic [WORD_W-1:0] adc_hdr_reg;
    logic [WORD_W-1:0] tdc_low_hdr_reg;
    logic [WORD_W-1:0] tdc_high_hdr_reg;

    // parser state
    mode_t      mode_reg, mode_next;
    kind_t      kind_reg, kind_next;
    logic [3:0] words_left_reg, words_left_next;
    logic       stopped_reg, stopped_next;
    logic       look_hdr;
    logic [3:0] wl_dec;

    // channel store
    logic signed [VALUE_W-1:0] adc_store_reg [ADC_CHANNELS];
    logic signed [VALUE_W-1:0] tdc_store_reg [TDC_CHANNELS];

    // data word decode
    logic [SEL_W-1:0]          sel;
    logic [RAW_W-1:0]          raw;
    logic signed [VALUE_W-1:0] data_val;
    logic [CHAN_W-1:0]         tdc_ch;
    logic                      data_we;
    logic                      adc_we;
    logic                      tdc_we;

    // dump counter and output register
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          tdc_cnt;
    logic                      sel_adc;
    logic                      cnt_last;
    logic                      out_valid_reg;
    logic                      out_is_tdc_reg;
    logic [CHAN_W-1:0]         out_channel_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      out_last_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adc_hdr_reg      <= ADC_HDR_RESET;
            tdc_low_hdr_reg  <= TDC_LOW_HDR_RESET;
            tdc_high_hdr_reg <= TDC_HIGH_HDR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ADC_HDR:      adc_hdr_reg      <= cfg_data;
                REG_TDC_LOW_HDR:  tdc_low_hdr_reg  <= cfg_data;
                REG_TDC_HIGH_HDR: tdc_high_hdr_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // parser next state
    always_comb
    begin
        mode_next       = mode_reg;
        kind_next       = kind_reg;
        words_left_next = words_left_reg;
        stopped_next    = stopped_reg;
        look_hdr        = 1'b0;
        wl_dec          = (words_left_reg != 4'd0) ? (words_left_reg - 4'd1) : words_left_reg;
        if (cmd.preset)
        begin
            mode_next       = MODE_IDLE;
            kind_next       = KIND_ADC;
            words_left_next = 4'd0;
            stopped_next    = 1'b0;
        end
        else if (cmd.take_word && !stopped_reg)
        begin
            case (mode_reg)
                MODE_COUNT:
                begin
                    if (word[WORD_W-1])
                    begin
                        words_left_next = {1'b0, word[14:12]} + 4'd1;
                        mode_next       = MODE_DATA;
                    end
                    else
                    begin
                        look_hdr = 1'b1;
                    end
                end
                MODE_DATA:
                begin
                    words_left_next = wl_dec;
                    if (wl_dec == 4'd0)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                default:
                begin
                    look_hdr = 1'b1;
                end
            endcase
            // header search, adc first
            if (look_hdr)
            begin
                if (word == '0)
                begin
                    stopped_next = 1'b1;
                    mode_next    = MODE_IDLE;
                end
                else if (word == adc_hdr_reg)
                begin
                    kind_next = KIND_ADC;
                    mode_next = MODE_COUNT;
                end
                else if (word == tdc_low_hdr_reg)
                begin
                    kind_next = KIND_TDC_LOW;
                    mode_next = MODE_COUNT;
                end
                else if (word == tdc_high_hdr_reg)
                begin
                    kind_next = KIND_TDC_HIGH;
                    mode_next = MODE_COUNT;
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
        end
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            kind_reg       <= KIND_ADC;
            words_left_reg <= 4'd0;
            stopped_reg    <= 1'b0;
        end
        else
        begin
            mode_reg       <= mode_next;
            kind_reg       <= kind_next;
            words_left_reg <= words_left_next;
            stopped_reg    <= stopped_next;
        end
    end

    // data word decode, overflow code reads as zero
    always_comb
    begin
        sel      = word[14:12];
        raw      = word[RAW_W-1:0];
        data_val = (raw == RAW_OVERFLOW) ? '0 : $signed({1'b0, raw});
        tdc_ch   = {(kind_reg == KIND_TDC_HIGH), sel};
        data_we  = cmd.take_word && !stopped_reg && (mode_reg == MODE_DATA);
        adc_we   = data_we && (kind_reg == KIND_ADC) && (int'(sel) < ADC_CHANNELS);
        tdc_we   = data_we && (kind_reg != KIND_ADC) && (int'(tdc_ch) < TDC_CHANNELS);
    end

    // adc store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ADC_CHANNELS; i++)
            begin
                adc_store_reg[i] <= adc_preset(i);
            end
        end
        else if (cmd.preset)
        begin
            for (int i = 0; i < ADC_CHANNELS; i++)
            begin
                adc_store_reg[i] <= adc_preset(i);
            end
        end
        else if (adc_we)
        begin
            adc_store_reg[sel[ADC_IW-1:0]] <= data_val;
        end
    end

    // tdc store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TDC_CHANNELS; i++)
            begin
                tdc_store_reg[i] <= tdc_preset(i);
            end
        end
        else if (cmd.preset)
        begin
            for (int i = 0; i < TDC_CHANNELS; i++)
            begin
                tdc_store_reg[i] <= tdc_preset(i);
            end
        end
        else if (tdc_we)
        begin
            tdc_store_reg[tdc_ch[TDC_IW-1:0]] <= data_val;
        end
    end

    // dump position decode
    always_comb
    begin
        sel_adc  = (int'(cnt_reg) < ADC_CHANNELS);
        tdc_cnt  = cnt_reg - CNT_W'(ADC_CHANNELS);
        cnt_last = (cnt_reg == CNT_W'(TOTAL - 1));
    end

    // dump counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            cnt_reg <= cnt_last ? '0 : (cnt_reg + CNT_W'(1));
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_item)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            out_last_reg <= cnt_last;
            if (sel_adc)
            begin
                out_is_tdc_reg  <= 1'b0;
                out_channel_reg <= CHAN_W'(cnt_reg);
                out_value_reg   <= adc_store_reg[cnt_reg[ADC_IW-1:0]];
            end
            else
            begin
                out_is_tdc_reg  <= 1'b1;
                out_channel_reg <= CHAN_W'(tdc_cnt);
                out_value_reg   <= tdc_store_reg[tdc_cnt[TDC_IW-1:0]];
            end
        end
    end

    assign status.out_valid = out_valid_reg;
    assign status.dump_last = cnt_last;
    assign out_valid        = out_valid_reg;
    assign out_is_tdc       = out_is_tdc_reg;
    assign out_channel      = out_channel_reg;
    assign out_value        = out_value_reg;
    assign out_last         = out_last_reg;

endmodule

[bench/subevent_dump_checker.sv]
module subevent_dump_checker
    import atsu_pkg::*;
#(
    parameter int ADC_CHANNELS = 8,
    parameter int TDC_CHANNELS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [WORD_W-1:0]    s_tdata,
    input  logic                 s_tlast,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [23:0]          m_tdata,
    input  logic                 m_tuser,
    input  logic                 m_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output int                   fail_count,
    output int                   pending,
    output int                   words_seen,
    output int                   results_seen
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic               is_tdc;
        logic [CHAN_W-1:0]  channel;
        logic [VALUE_W-1:0] value;
        logic               last;
    } chan_result_t;

    // predicted header codes, parser and channel store
    logic [WORD_W-1:0]  adc_code;
    logic [WORD_W-1:0]  tdc_low_code;
    logic [WORD_W-1:0]  tdc_high_code;
    mode_t              mode;
    kind_t              kind;
    logic [3:0]         words_left;
    logic               halted;
    logic [VALUE_W-1:0] adc_store [ADC_CHANNELS];
    logic [VALUE_W-1:0] tdc_store [TDC_CHANNELS];

    // channel results still owed by the block, oldest first
    chan_result_t       expected_channels [$];
    int                 errors;
    int                 word_total;
    int                 result_total;

    // preset pattern that marks channels without a hit
    function automatic void preset_stores();
        for (int i = 0; i < ADC_CHANNELS; i++)
            adc_store[i] = VALUE_W'(-(i + 1));
        for (int i = 0; i < TDC_CHANNELS; i++)
            tdc_store[i] = VALUE_W'(-10 * (i + 1));
    endfunction

    function automatic void clear_parser();
        mode       = MODE_IDLE;
        kind       = KIND_ADC;
        words_left = '0;
        halted     = 1'b0;
    endfunction

    // idle handling: zero stops the event, header codes in priority order
    function automatic void seek_header(input logic [WORD_W-1:0] w);
        if (w == '0)
        begin
            halted = 1'b1;
            mode   = MODE_IDLE;
        end
        else if (w == adc_code)
        begin
            kind = KIND_ADC;
            mode = MODE_COUNT;
        end
        else if (w == tdc_low_code)
        begin
            kind = KIND_TDC_LOW;
            mode = MODE_COUNT;
        end
        else if (w == tdc_high_code)
        begin
            kind = KIND_TDC_HIGH;
            mode = MODE_COUNT;
        end
        else
            mode = MODE_IDLE;
    endfunction

    // data word: channel select and raw value, overflow code reads as zero
    function automatic void store_value(input logic [WORD_W-1:0] w);
        logic [SEL_W-1:0]   sel;
        logic [VALUE_W-1:0] v;
        int                 idx;
        sel = w[14:12];
        v   = (w[RAW_W-1:0] == RAW_OVERFLOW) ? '0 : VALUE_W'(w[RAW_W-1:0]);
        if (kind == KIND_ADC)
        begin
            if (int'(sel) < ADC_CHANNELS)
                adc_store[sel] = v;
        end
        else
        begin
            idx = int'(sel) + ((kind == KIND_TDC_HIGH) ? 8 : 0);
            if (idx < TDC_CHANNELS)
                tdc_store[idx] = v;
        end
    endfunction

    function automatic void unpack_word(input logic [WORD_W-1:0] w);
        if (!halted)
        begin
            case (mode)
                MODE_COUNT:
                begin
                    // count word needs bit 15, otherwise the word is looked at again
                    if (w[15])
                    begin
                        words_left = 4'(w[14:12]) + 4'd1;
                        mode       = MODE_DATA;
                    end
                    else
                        seek_header(w);
                end
                MODE_DATA:
                begin
                    store_value(w);
                    if (words_left != 0)
                        words_left--;
                    if (words_left == 0)
                        mode = MODE_IDLE;
                end
                default:
                    seek_header(w);
            endcase
        end
    endfunction

    // event end: every channel, adc then tdc, then back to the preset
    function automatic void queue_dump();
        chan_result_t r;
        int           total;
        total = ADC_CHANNELS + TDC_CHANNELS;
        for (int i = 0; i < ADC_CHANNELS; i++)
        begin
            r.is_tdc  = 1'b0;
            r.channel = CHAN_W'(i);
            r.value   = adc_store[i];
            r.last    = (i == total - 1);
            expected_channels.push_back(r);
        end
        for (int i = 0; i < TDC_CHANNELS; i++)
        begin
            r.is_tdc  = 1'b1;
            r.channel = CHAN_W'(i);
            r.value   = tdc_store[i];
            r.last    = (ADC_CHANNELS + i == total - 1);
            expected_channels.push_back(r);
        end
        preset_stores();
        clear_parser();
    endfunction

    function automatic void report(input string field, input int want, input int got);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        chan_result_t oldest;
        if (!rst_n)
        begin
            adc_code      = ADC_HDR_RESET;
            tdc_low_code  = TDC_LOW_HDR_RESET;
            tdc_high_code = TDC_HIGH_HDR_RESET;
            clear_parser();
            preset_stores();
            expected_channels.delete();
            pending <= 0;
        end
        else
        begin
            // a result leaves before the request of the same edge is predicted
            if (m_tvalid && m_tready)
            begin
                result_total++;
                if (expected_channels.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual channel %0d value %0d",
                                 $time, m_tdata[3:0], $signed(m_tdata[16:4]));
                end
                else
                begin
                    oldest = expected_channels.pop_front();
                    if (m_tuser !== oldest.is_tdc)
                        report("is_tdc", oldest.is_tdc, m_tuser);
                    if (m_tdata[3:0] !== oldest.channel)
                        report("channel", oldest.channel, m_tdata[3:0]);
                    if (m_tdata[16:4] !== oldest.value)
                        report("value", $signed(oldest.value), $signed(m_tdata[16:4]));
                    if (m_tlast !== oldest.last)
                        report("last_item", oldest.last, m_tlast);
                    if (m_tdata[23:17] !== '0)
                        report("tdata padding", 0, m_tdata[23:17]);
                end
            end

            // header code writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ADC_HDR:      adc_code      = cfg_data;
                    REG_TDC_LOW_HDR:  tdc_low_code  = cfg_data;
                    REG_TDC_HIGH_HDR: tdc_high_code = cfg_data;
                    default: ;
                endcase
            end

            // readout word request
            if (s_tvalid && s_tready)
            begin
                word_total++;
                unpack_word(s_tdata);
                if (s_tlast)
                    queue_dump();
            end

            pending <= expected_channels.size();
        end
        fail_count   <= errors;
        words_seen   <= word_total;
        results_seen <= result_total;
    end

endmodule

[bench/detector_adc_tdc_subevent_unpacker_top_tb.sv]
module detector_adc_tdc_subevent_unpacker_top_tb;
    import atsu_pkg::*;

    localparam int ADC_CHANNELS    = 8;
    localparam int TDC_CHANNELS    = 16;
    localparam int WORDS_PER_PHASE = 10;
    localparam int DRAIN_CYCLES    = 32;
    localparam int LONG_HOLD       = 200;
    localparam int HOLD_AT_RESULT  = 10;
    localparam int STALL_LIMIT     = 2000;

    logic                 clk;
    logic                 rst_n;
    logic [WORD_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    int                   fail_count;
    int                   pending;
    int                   words_seen;
    int                   results_seen;

    // header codes currently loaded, by register index
    logic [WORD_W-1:0]    hdr_codes [3];
    logic                 quiet;
    int                   words_sent;
    int                   events_sent;
    int                   settings_used;

    detector_adc_tdc_subevent_unpacker_top #(
        .ADC_CHANNELS (ADC_CHANNELS),
        .TDC_CHANNELS (TDC_CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    subevent_dump_checker #(
        .ADC_CHANNELS (ADC_CHANNELS),
        .TDC_CHANNELS (TDC_CHANNELS)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .words_seen   (words_seen),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // one readout word; valid stays high so back-to-back words need no gap
    task automatic send_readout_word(input logic [WORD_W-1:0] w, input logic last);
        int gap;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= w;
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
        if (last)
            events_sent++;
    endtask

    // stop sending and wait until every dump has been taken
    task automatic drain_dumps();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        hdr_codes[idx] = v;
    endtask

    task automatic write_header_codes(input logic [WORD_W-1:0] adc,
                                      input logic [WORD_W-1:0] tdc_low,
                                      input logic [WORD_W-1:0] tdc_high);
        write_reg(REG_ADC_HDR, adc);
        write_reg(REG_TDC_LOW_HDR, tdc_low);
        write_reg(REG_TDC_HIGH_HDR, tdc_high);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [WORD_W-1:0] pick_header();
        return hdr_codes[CFG_IDX_W'($urandom_range(REG_ADC_HDR, REG_TDC_HIGH_HDR))];
    endfunction

    // one subevent: mostly proper blocks, some noise, broken counts and stops
    task automatic send_subevent();
        logic [WORD_W-1:0] words [$];
        logic [WORD_W-1:0] w;
        int                blocks;
        int                count;
        int                style;
        int                cut;
        blocks = $urandom_range(1, 3);
        for (int b = 0; b < blocks; b++)
        begin
            style = $urandom_range(0, 9);
            if (style < 7)
            begin
                count = $urandom_range(1, 8);
                words.push_back(pick_header());
                words.push_back({1'b1, 3'(count - 1), 12'($urandom)});
                for (int k = 0; k < count; k++)
                begin
                    w = 16'($urandom);
                    if ($urandom_range(0, 5) == 0)
                        w[RAW_W-1:0] = RAW_OVERFLOW;
                    if ($urandom_range(0, 15) == 0)
                        w = '0;
                    words.push_back(w);
                end
            end
            else if (style == 7)
            begin
                count = $urandom_range(1, 3);
                for (int k = 0; k < count; k++)
                    words.push_back(16'($urandom));
            end
            else if (style == 8)
            begin
                // count word without bit 15
                words.push_back(pick_header());
                if ($urandom_range(0, 1) == 0)
                    words.push_back(pick_header());
                else
                    words.push_back(16'($urandom) & 16'h7fff);
            end
            else
            begin
                words.push_back('0);
                words.push_back(pick_header());
                words.push_back(16'($urandom));
            end
        end
        // sometimes the event ends inside a block
        if (words.size() > 1 && $urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, words.size() - 1);
            repeat (cut) void'(words.pop_back());
        end
        for (int i = 0; i < words.size(); i++)
            send_readout_word(words[i], i == words.size() - 1);
    endtask

    task automatic run_random(input int n);
        int start;
        start = words_sent;
        while (words_sent - start < n)
            send_subevent();
    endtask

    // receiver: random hold-offs, one long stall early, none at the end
    initial
    begin : receiver
        int   gap;
        logic held_long;
        held_long = 1'b0;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held_long && results_seen >= HOLD_AT_RESULT)
            begin
                held_long = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 18);
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no request on any channel
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        logic [WORD_W-1:0] twin_code;
        rst_n     <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_ADC_HDR;
        cfg_data  <= '0;
        quiet         = 1'b0;
        words_sent    = 0;
        events_sent   = 0;
        settings_used = 0;
        hdr_codes[REG_ADC_HDR]      = ADC_HDR_RESET;
        hdr_codes[REG_TDC_LOW_HDR]  = TDC_LOW_HDR_RESET;
        hdr_codes[REG_TDC_HIGH_HDR] = TDC_HIGH_HDR_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all three block kinds, count of 8 and of 1, overflow raw value,
        // bit 15 set on data words, top tdc channel
        send_readout_word(ADC_HDR_RESET, 1'b0);
        send_readout_word(16'hf000, 1'b0);
        send_readout_word(16'h0fff, 1'b0);
        send_readout_word(16'h9ffe, 1'b0);
        send_readout_word(16'h2000, 1'b0);
        send_readout_word(16'h3123, 1'b0);
        send_readout_word(16'h4456, 1'b0);
        send_readout_word(16'h5789, 1'b0);
        send_readout_word(16'h6abc, 1'b0);
        send_readout_word(16'h7001, 1'b0);
        send_readout_word(TDC_LOW_HDR_RESET, 1'b0);
        send_readout_word(16'h8000, 1'b0);
        send_readout_word(16'h7555, 1'b0);
        send_readout_word(TDC_HIGH_HDR_RESET, 1'b0);
        send_readout_word(16'h8000, 1'b0);
        send_readout_word(16'hfbcd, 1'b1);

        // count word without bit 15 taken as a header, zero as data,
        // zero in idle stops the event and later words are ignored
        send_readout_word(TDC_LOW_HDR_RESET, 1'b0);
        send_readout_word(ADC_HDR_RESET, 1'b0);
        send_readout_word(16'h8000, 1'b0);
        send_readout_word(16'h0000, 1'b0);
        send_readout_word(16'h0000, 1'b0);
        send_readout_word(TDC_HIGH_HDR_RESET, 1'b1);

        run_random(WORDS_PER_PHASE);
        drain_dumps();

        // arbitrary header codes
        write_header_codes(16'($urandom), 16'($urandom), 16'($urandom));
        run_random(WORDS_PER_PHASE);
        drain_dumps();

        // all codes at the top of the range: adc wins, event ends mid-block
        write_header_codes(16'hffff, 16'hffff, 16'hffff);
        send_readout_word(16'hffff, 1'b0);
        send_readout_word(16'hf000, 1'b0);
        send_readout_word(16'h0123, 1'b0);
        send_readout_word(16'h1fff, 1'b1);
        run_random(WORDS_PER_PHASE);
        drain_dumps();

        // zero adc code never opens a block; equal tdc codes go to the low bank
        twin_code = 16'($urandom_range(1, 65535));
        write_header_codes(16'h0000, twin_code, twin_code);
        send_readout_word(twin_code, 1'b0);
        send_readout_word(16'h8000, 1'b0);
        send_readout_word(16'h3456, 1'b1);
        run_random(WORDS_PER_PHASE);
        drain_dumps();

        // reset codes again, both sides without idling
        quiet = 1'b1;
        write_header_codes(ADC_HDR_RESET, TDC_LOW_HDR_RESET, TDC_HIGH_HDR_RESET);
        run_random(WORDS_PER_PHASE);
        drain_dumps();

        $display("run: %0d readout words in %0d subevents, %0d header code settings",
                 words_seen, events_sent, settings_used + 1);
        $display("run: %0d channel results compared, %0d mismatches, %0d still owed",
                 results_seen, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
